FILE: rtl/just_intonation_pitch_quantizer_defines.svh
// assertion macros for the just-intonation pitch quantizer
// expects clk and rst_n in the scope of every use
`ifndef JUST_INTONATION_PITCH_QUANTIZER_DEFINES_SVH
`define JUST_INTONATION_PITCH_QUANTIZER_DEFINES_SVH

// same-cycle implication, held off during reset
`define JIPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define JIPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/jipq_pkg.sv
// shared widths, constants, ratio tables and stage types of the pitch quantizer
// no dependencies
package jipq_pkg;

  localparam int FREQ_FRAC_BITS = 16;
  localparam int FREQ_W  = 32;
  localparam int QF_W    = 34;
  localparam int DEG_W   = 4;
  localparam int OCT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int N_DEG   = 13;
  localparam int NUM_W   = 6;
  localparam int DEN_W   = 6;
  localparam int SCALE_W = 10;
  localparam int DIST_W  = 42;
  localparam int OUT_W   = 48;
  localparam int CFG_IDX_W = 1;

  localparam int OCT_MAX  = 31;
  localparam int DEG8_MAX = 7;
  // common denominator of every ratio in the tables
  localparam int LCD_SCALE = 480;

  localparam logic [FREQ_W-1:0] REF_RESET =
    FREQ_W'(((64'd261626 << FREQ_FRAC_BITS) + 64'd500) / 64'd1000);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEL = 1'b1;

  localparam logic SCALE_12 = 1'b0;
  localparam logic SCALE_8  = 1'b1;

  // degrees of the 12-tone table that also form the 8-tone table
  localparam logic [N_DEG-1:0] TAB8_MASK = 13'b1_1010_1011_0101;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] base;
    logic [OCT_W-1:0]  oct;
  } octave_t;

  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] gap;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  typedef struct packed {
    logic [FREQ_W-1:0] base;
    logic [OCT_W-1:0]  oct;
    logic [IDX_W-1:0]  idx;
  } pick_t;

  // ratio times 480, exact for every entry
  function automatic logic [SCALE_W-1:0] scaled_num(input logic [IDX_W-1:0] idx);
    logic [SCALE_W-1:0] m;
    case (idx)
      4'd0:    m = 10'd480;
      4'd1:    m = 10'd512;
      4'd2:    m = 10'd540;
      4'd3:    m = 10'd576;
      4'd4:    m = 10'd600;
      4'd5:    m = 10'd640;
      4'd6:    m = 10'd675;
      4'd7:    m = 10'd720;
      4'd8:    m = 10'd768;
      4'd9:    m = 10'd800;
      4'd10:   m = 10'd864;
      4'd11:   m = 10'd900;
      default: m = 10'd960;
    endcase
    return m;
  endfunction

  function automatic logic [NUM_W-1:0] ratio_num(input logic [IDX_W-1:0] idx);
    logic [NUM_W-1:0] n;
    case (idx)
      4'd0:    n = 6'd1;
      4'd1:    n = 6'd16;
      4'd2:    n = 6'd9;
      4'd3:    n = 6'd6;
      4'd4:    n = 6'd5;
      4'd5:    n = 6'd4;
      4'd6:    n = 6'd45;
      4'd7:    n = 6'd3;
      4'd8:    n = 6'd8;
      4'd9:    n = 6'd5;
      4'd10:   n = 6'd9;
      4'd11:   n = 6'd15;
      default: n = 6'd2;
    endcase
    return n;
  endfunction

  function automatic logic [DEN_W-1:0] ratio_den(input logic [IDX_W-1:0] idx);
    logic [DEN_W-1:0] d;
    case (idx)
      4'd0:    d = 6'd1;
      4'd1:    d = 6'd15;
      4'd2:    d = 6'd8;
      4'd3:    d = 6'd5;
      4'd4:    d = 6'd4;
      4'd5:    d = 6'd3;
      4'd6:    d = 6'd32;
      4'd7:    d = 6'd2;
      4'd8:    d = 6'd5;
      4'd9:    d = 6'd3;
      4'd10:   d = 6'd5;
      4'd11:   d = 6'd8;
      default: d = 6'd1;
    endcase
    return d;
  endfunction

  // position of a 12-tone degree within the 8-tone table
  function automatic logic [DEG_W-1:0] deg8(input logic [IDX_W-1:0] idx);
    logic [DEG_W-1:0] g;
    case (idx)
      4'd2:    g = 4'd1;
      4'd4:    g = 4'd2;
      4'd5:    g = 4'd3;
      4'd7:    g = 4'd4;
      4'd9:    g = 4'd5;
      4'd11:   g = 4'd6;
      4'd12:   g = 4'd7;
      default: g = 4'd0;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/jipq_octave.sv
// octave search: two stages, leading-one alignment then one compare
// depends on jipq_pkg
module jipq_octave (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [jipq_pkg::FREQ_W-1:0]   in_freq,
  input  logic [jipq_pkg::FREQ_W-1:0]   ref_freq,
  output logic                          out_vld,
  output jipq_pkg::octave_t             out_oct
);

  logic                        s1_vld_r;
  logic [jipq_pkg::FREQ_W-1:0] s1_freq_r, s1_freq_nxt;
  logic [jipq_pkg::FREQ_W-1:0] s1_shift_r, s1_shift_nxt;
  logic [jipq_pkg::OCT_W-1:0]  s1_d_r, s1_d_nxt;
  logic                        s1_rzero_r, s1_rzero_nxt;
  logic                        s1_below_r, s1_below_nxt;
  logic [jipq_pkg::OCT_W-1:0]  pos_f, pos_r;

  logic                        s2_vld_r;
  jipq_pkg::octave_t           s2_r, s2_nxt;

  function automatic logic [jipq_pkg::OCT_W-1:0] msb_pos(
    input logic [jipq_pkg::FREQ_W-1:0] v);
    logic [jipq_pkg::OCT_W-1:0] p;
    p = '0;
    for (int i = 0; i < jipq_pkg::FREQ_W; i++) begin
      if (v[i]) p = jipq_pkg::OCT_W'(i);
    end
    return p;
  endfunction

  // align leading ones of reference and input
  always_comb begin
    pos_f        = msb_pos(in_freq);
    pos_r        = msb_pos(ref_freq);
    s1_freq_nxt  = in_freq;
    s1_rzero_nxt = (ref_freq == '0);
    s1_below_nxt = (in_freq < ref_freq);
    s1_d_nxt     = pos_f - pos_r;
    s1_shift_nxt = s1_below_nxt ? ref_freq : (ref_freq << s1_d_nxt);
  end

  // aligned reference may overshoot by one octave
  always_comb begin
    s2_nxt.freq = s1_freq_r;
    if (s1_rzero_r) begin
      s2_nxt.oct  = jipq_pkg::OCT_W'(jipq_pkg::OCT_MAX);
      s2_nxt.base = '0;
    end else if (s1_below_r) begin
      s2_nxt.oct  = '0;
      s2_nxt.base = s1_shift_r;
    end else if (s1_shift_r > s1_freq_r) begin
      s2_nxt.oct  = s1_d_r - jipq_pkg::OCT_W'(1);
      s2_nxt.base = s1_shift_r >> 1;
    end else begin
      s2_nxt.oct  = s1_d_r;
      s2_nxt.base = s1_shift_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_freq_r  <= s1_freq_nxt;
      s1_shift_r <= s1_shift_nxt;
      s1_d_r     <= s1_d_nxt;
      s1_rzero_r <= s1_rzero_nxt;
      s1_below_r <= s1_below_nxt;
      s2_r       <= s2_nxt;
    end
  end

  assign out_vld = s2_vld_r;
  assign out_oct = s2_r;

endmodule

FILE: rtl/jipq_nearest.sv
// nearest-degree search: one stage of distances, two stages of registered min tree
// depends on jipq_pkg
module jipq_nearest (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              scale_sel,
  input  logic              in_vld,
  input  jipq_pkg::octave_t in_oct,
  output logic              out_vld,
  output jipq_pkg::pick_t   out_pick
);

  localparam int N_GRP = 4;

  logic                        s3_vld_r;
  jipq_pkg::cand_t             s3_cand_r [jipq_pkg::N_DEG];
  jipq_pkg::cand_t             s3_cand_nxt [jipq_pkg::N_DEG];
  logic [jipq_pkg::FREQ_W-1:0] s3_base_r;
  logic [jipq_pkg::OCT_W-1:0]  s3_oct_r;
  logic [jipq_pkg::DIST_W-1:0] freq_scaled;
  logic [jipq_pkg::DIST_W-1:0] cand_freq [jipq_pkg::N_DEG];

  logic                        s4_vld_r;
  jipq_pkg::cand_t             s4_grp_r [N_GRP];
  jipq_pkg::cand_t             s4_grp_nxt [N_GRP];
  logic [jipq_pkg::FREQ_W-1:0] s4_base_r;
  logic [jipq_pkg::OCT_W-1:0]  s4_oct_r;

  logic                        s5_vld_r;
  jipq_pkg::pick_t             s5_r;
  jipq_pkg::cand_t             win;

  // right side wins only when strictly nearer, so lower degrees keep ties
  function automatic jipq_pkg::cand_t better(input jipq_pkg::cand_t a,
                                             input jipq_pkg::cand_t b);
    jipq_pkg::cand_t c;
    c = (b.vld && (!a.vld || (b.gap < a.gap))) ? b : a;
    return c;
  endfunction

  // distances on the common denominator: |480 f - base * 480 ratio|
  always_comb begin
    freq_scaled = jipq_pkg::DIST_W'(in_oct.freq) * jipq_pkg::DIST_W'(jipq_pkg::LCD_SCALE);
    for (int i = 0; i < jipq_pkg::N_DEG; i++) begin
      cand_freq[i] = jipq_pkg::DIST_W'(in_oct.base) *
                     jipq_pkg::DIST_W'(jipq_pkg::scaled_num(jipq_pkg::IDX_W'(i)));
      s3_cand_nxt[i].gap = (freq_scaled >= cand_freq[i]) ? (freq_scaled - cand_freq[i])
                                                         : (cand_freq[i] - freq_scaled);
      s3_cand_nxt[i].idx = jipq_pkg::IDX_W'(i);
      s3_cand_nxt[i].vld = (scale_sel == jipq_pkg::SCALE_12) || jipq_pkg::TAB8_MASK[i];
    end
  end

  always_comb begin
    s4_grp_nxt[0] = better(better(s3_cand_r[0], s3_cand_r[1]),
                           better(s3_cand_r[2], s3_cand_r[3]));
    s4_grp_nxt[1] = better(better(s3_cand_r[4], s3_cand_r[5]),
                           better(s3_cand_r[6], s3_cand_r[7]));
    s4_grp_nxt[2] = better(better(s3_cand_r[8], s3_cand_r[9]),
                           better(s3_cand_r[10], s3_cand_r[11]));
    s4_grp_nxt[3] = s3_cand_r[12];
    win = better(better(s4_grp_r[0], s4_grp_r[1]), better(s4_grp_r[2], s4_grp_r[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= in_vld;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cand_r <= s3_cand_nxt;
      s3_base_r <= in_oct.base;
      s3_oct_r  <= in_oct.oct;
      s4_grp_r  <= s4_grp_nxt;
      s4_base_r <= s3_base_r;
      s4_oct_r  <= s3_oct_r;
      s5_r.base <= s4_base_r;
      s5_r.oct  <= s4_oct_r;
      s5_r.idx  <= win.idx;
    end
  end

  assign out_vld  = s5_vld_r;
  assign out_pick = s5_r;

endmodule

FILE: rtl/jipq_product.sv
// candidate frequency floor(base * num / den): reciprocal quotient stage, then fix-up
// depends on jipq_pkg
module jipq_product (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  jipq_pkg::pick_t              in_pick,
  output logic                         out_vld,
  output logic [jipq_pkg::QF_W-1:0]    out_freq,
  output logic [jipq_pkg::IDX_W-1:0]   out_idx,
  output logic [jipq_pkg::OCT_W-1:0]   out_oct
);

  localparam int RECIP_W = 33;
  localparam int PROD_W  = RECIP_W + jipq_pkg::FREQ_W;
  localparam int SMALL_W = 11;
  localparam int FRAC_W  = 6;
  localparam int QN_W    = jipq_pkg::FREQ_W + jipq_pkg::NUM_W;
  localparam int REM_W   = 5;

  logic                        s6_vld_r;
  logic [jipq_pkg::FREQ_W-1:0] s6_q_r, s6_q_nxt;
  jipq_pkg::pick_t             s6_r;

  logic [jipq_pkg::DEN_W-1:0]  den_in;
  logic [RECIP_W-1:0]          recip;
  logic [5:0]                  rshift;
  logic [PROD_W-1:0]           prod;

  logic [jipq_pkg::NUM_W-1:0]  num;
  logic [jipq_pkg::DEN_W-1:0]  den;
  logic [jipq_pkg::FREQ_W-1:0] qd;
  logic [REM_W-1:0]            rem;
  logic [SMALL_W-1:0]          small_prod;
  logic [FRAC_W-1:0]           frac;
  logic [QN_W-1:0]             qn;

  // floor(x / den) as (x * recip) >> rshift, exact for every 32-bit x
  always_comb begin
    den_in = jipq_pkg::ratio_den(in_pick.idx);
    case (den_in)
      6'd2:    begin recip = 33'h0_8000_0000; rshift = 6'd32; end
      6'd3:    begin recip = 33'h0_AAAA_AAAB; rshift = 6'd33; end
      6'd4:    begin recip = 33'h0_4000_0000; rshift = 6'd32; end
      6'd5:    begin recip = 33'h0_CCCC_CCCD; rshift = 6'd34; end
      6'd8:    begin recip = 33'h0_2000_0000; rshift = 6'd32; end
      6'd15:   begin recip = 33'h0_8888_8889; rshift = 6'd35; end
      6'd32:   begin recip = 33'h0_0800_0000; rshift = 6'd32; end
      default: begin recip = 33'h1_0000_0000; rshift = 6'd32; end
    endcase
    prod     = PROD_W'(in_pick.base) * PROD_W'(recip);
    s6_q_nxt = jipq_pkg::FREQ_W'(prod >> rshift);
  end

  // q * num plus floor(rem * num / den); rem * num stays below 2^11
  always_comb begin
    num        = jipq_pkg::ratio_num(s6_r.idx);
    den        = jipq_pkg::ratio_den(s6_r.idx);
    qd         = s6_q_r * jipq_pkg::FREQ_W'(den);
    rem        = REM_W'(s6_r.base - qd);
    small_prod = SMALL_W'(rem) * SMALL_W'(num);
    case (den)
      6'd2:    frac = FRAC_W'(small_prod >> 1);
      6'd3:    frac = FRAC_W'((22'(small_prod) * 22'd683) >> 11);
      6'd4:    frac = FRAC_W'(small_prod >> 2);
      6'd5:    frac = FRAC_W'((22'(small_prod) * 22'd820) >> 12);
      6'd8:    frac = FRAC_W'(small_prod >> 3);
      6'd15:   frac = FRAC_W'((22'(small_prod) * 22'd547) >> 13);
      6'd32:   frac = FRAC_W'(small_prod >> 5);
      default: frac = '0;
    endcase
    qn       = QN_W'(s6_q_r) * QN_W'(num);
    out_freq = jipq_pkg::QF_W'(qn + QN_W'(frac));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_q_r <= s6_q_nxt;
      s6_r   <= in_pick;
    end
  end

  assign out_vld = s6_vld_r;
  assign out_idx = s6_r.idx;
  assign out_oct = s6_r.oct;

endmodule

FILE: rtl/just_intonation_pitch_quantizer.sv
// Just-intonation pitch quantizer. Every input word is an unsigned Q16.16
// frequency; the block folds it into octave k above the programmed reference
// (largest k up to 31 with reference * 2^k not above the input), picks the
// degree of the 12-tone or 8-tone just table whose frequency is nearest (lower
// degree on a tie, reference itself for inputs below it) and returns that
// frequency, truncated to Q18.16, with its degree and octave. One word is
// accepted every clock while in_tready is high; the result passes through the
// pipeline stages (input register, octave align, octave compare, distances,
// two min-tree levels, quotient, output register). A result that is held off
// by out_tready parks in a one-word skid register, and in_tready drops only
// while that skid register is full. The user must write configuration only
// while no word is in flight; the block itself does not enforce it.
// depends on jipq_pkg, jipq_octave, jipq_nearest, jipq_product and the defines header
`include "just_intonation_pitch_quantizer_defines.svh"

module just_intonation_pitch_quantizer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input_frequency [31:0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [jipq_pkg::FREQ_W-1:0]      in_tdata,
  // quantized_frequency [33:0], degree_index [37:34], octave_shift [42:38], zero fill
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [jipq_pkg::OUT_W-1:0]       out_tdata,
  // register 0 reference_frequency, register 1 scale_select
  input  logic                             cfg_wr_en,
  input  logic [jipq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jipq_pkg::FREQ_W-1:0]      cfg_wdata
);

  localparam int QF_LO  = 0;
  localparam int DEG_LO = QF_LO + jipq_pkg::QF_W;
  localparam int OCT_LO = DEG_LO + jipq_pkg::DEG_W;
  localparam int PAD_LO = OCT_LO + jipq_pkg::OCT_W;
  localparam int PAD_W  = jipq_pkg::OUT_W - PAD_LO;

  // configuration
  logic [jipq_pkg::FREQ_W-1:0] ref_r;
  logic                        sel_r;

  // input register
  logic                        in_vld_r;
  logic [jipq_pkg::FREQ_W-1:0] in_freq_r;

  // whole pipeline moves together; it stops only while the skid word is held
  logic                        en;

  logic                        oct_vld;
  jipq_pkg::octave_t           oct_data;
  logic                        pick_vld;
  jipq_pkg::pick_t             pick_data;
  logic                        res_vld;
  logic [jipq_pkg::QF_W-1:0]   res_freq;
  logic [jipq_pkg::IDX_W-1:0]  res_idx;
  logic [jipq_pkg::OCT_W-1:0]  res_oct;
  logic [jipq_pkg::DEG_W-1:0]  res_deg;
  logic [jipq_pkg::OUT_W-1:0]  res_word;
  logic                        push;

  // output register and skid register
  logic                        out_vld_r, out_vld_nxt;
  logic [jipq_pkg::OUT_W-1:0]  out_word_r, out_word_nxt;
  logic                        skid_vld_r, skid_vld_nxt;
  logic [jipq_pkg::OUT_W-1:0]  skid_word_r, skid_word_nxt;

  // output word fields and conditions seen by the checks at the end
  logic [jipq_pkg::DEG_W-1:0]  chk_deg;
  logic                        chk_deg_ok;
  logic                        chk_sel8;
  logic                        chk_ref0;
  logic                        chk_zero;
  logic                        chk_drain;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= jipq_pkg::REF_RESET;
      sel_r <= jipq_pkg::SCALE_12;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jipq_pkg::CFG_IDX_REF: ref_r <= cfg_wdata;
        jipq_pkg::CFG_IDX_SEL: sel_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_freq_r <= in_tdata;
    end
  end

  jipq_octave u_octave (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_vld_r),
    .in_freq  (in_freq_r),
    .ref_freq (ref_r),
    .out_vld  (oct_vld),
    .out_oct  (oct_data)
  );

  jipq_nearest u_nearest (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .scale_sel (sel_r),
    .in_vld    (oct_vld),
    .in_oct    (oct_data),
    .out_vld   (pick_vld),
    .out_pick  (pick_data)
  );

  jipq_product u_product (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (pick_vld),
    .in_pick  (pick_data),
    .out_vld  (res_vld),
    .out_freq (res_freq),
    .out_idx  (res_idx),
    .out_oct  (res_oct)
  );

  // degrees are searched on the 12-tone numbering, renumber for the 8-tone table
  assign res_deg  = (sel_r == jipq_pkg::SCALE_8) ? jipq_pkg::deg8(res_idx) : res_idx;
  assign res_word = {PAD_W'(0), res_oct, res_deg, res_freq};
  // a held final stage must not be pushed twice
  assign push     = en && res_vld;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_word_nxt  = out_word_r;
    skid_vld_nxt  = skid_vld_r;
    skid_word_nxt = skid_word_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        // drain the parked word first
        out_vld_nxt  = 1'b1;
        out_word_nxt = skid_word_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = push;
        out_word_nxt = res_word;
      end
    end else if (push) begin
      // output stalled: park the new word
      skid_vld_nxt  = 1'b1;
      skid_word_nxt = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_word_r;

  assign chk_deg    = out_word_r[OCT_LO-1:DEG_LO];
  assign chk_deg_ok = (chk_deg <= jipq_pkg::DEG_W'(jipq_pkg::DEG8_MAX));
  assign chk_sel8   = out_vld_r && (sel_r == jipq_pkg::SCALE_8);
  assign chk_ref0   = out_vld_r && (ref_r == '0);
  assign chk_zero   = (out_word_r[DEG_LO-1:QF_LO] == '0) && (chk_deg == '0) &&
                      (out_word_r[PAD_LO-1:OCT_LO] == jipq_pkg::OCT_W'(jipq_pkg::OCT_MAX));
  assign chk_drain  = skid_vld_r && out_tready;

  // a parked word always sits behind a valid output word
  `JIPQ_ASSERT_NOW(a_skid_behind_out, skid_vld_r, out_vld_r, "skid word without output word")
  // once the output is taken, the parked word moves up in the next cycle
  `JIPQ_ASSERT_NEXT(a_skid_drains, chk_drain, out_vld_r && !skid_vld_r, "skid word not drained")
  // the 8-tone table has degrees 0 to 7 only
  `JIPQ_ASSERT_NOW(a_deg8_range, chk_sel8, chk_deg_ok, "degree beyond 8-tone table")
  // a zero reference folds every input to frequency 0, degree 0, top octave
  `JIPQ_ASSERT_NOW(a_zero_ref, chk_ref0, chk_zero, "zero reference result wrong")

endmodule
